@@ sv/first_fit_heap_allocator_assert.svh @@
// Assertion macros for the first-fit heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FFH_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define FFH_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

@@ sv/ffha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and codes shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam logic       OP_ALLOC    = 1'b0;
    localparam logic       OP_FREE     = 1'b1;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OOM      = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;
    localparam int unsigned MINALLOC   = 8;

    typedef struct packed {
        logic        operation;
        logic [31:0] request_size;
        logic [47:0] release_address;
    } t_req;

    typedef struct packed {
        logic [47:0] block_address;
        logic [1:0]  status;
    } t_rsp;

endpackage

@@ sv/first_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an address-ordered segment table with split and
// two-sided coalesce on free.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats (allocate or free) arrive on i_req_valid/o_req_ready; one
//   response beat per request leaves on o_rsp_valid/i_rsp_ready.
//   APB registers (8-byte stride, 64-bit data): 0x0 heap_base, 0x8 heap_size.
//   A write to either rebuilds the table as one free segment; writes are
//   taken only while the block is idle.
//   The table sits in one synchronous memory (one read and one write port).
//   The search reads one entry per read/check state pair, in table order.
//   An allocate searches, then on a split shifts the tail up by one entry;
//   a miss ends after the search; a free searches, then does one tail shift
//   per merged neighbor. One request is in work at a time; o_req_ready
//   is high only while idle.
//   The response sits in an output register; a new request is accepted
//   while it waits to be taken, but the next response waits for the receiver.
//   Reset empties the table: allocates answer out of memory and frees
//   answer status 2 until a register is written.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output t_rsp        o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

`include "first_fit_heap_allocator_assert.svh"

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
    localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CFGW  = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_SCHK  = 4'd3;
    localparam logic [3:0] S_INS_R = 4'd4;
    localparam logic [3:0] S_INS_W = 4'd5;
    localparam logic [3:0] S_WR0   = 4'd6;
    localparam logic [3:0] S_WR1   = 4'd7;
    localparam logic [3:0] S_NRD   = 4'd8;
    localparam logic [3:0] S_NCHK  = 4'd9;
    localparam logic [3:0] S_PRD   = 4'd10;
    localparam logic [3:0] S_PCHK  = 4'd11;
    localparam logic [3:0] S_DEL_R = 4'd12;
    localparam logic [3:0] S_DEL_W = 4'd13;
    localparam logic [3:0] S_FWR   = 4'd14;
    localparam logic [3:0] S_RESP  = 4'd15;

    // entry: {free, length, offset}
    logic [64:0] mem [MAX_SEGMENTS];
    logic [64:0] r_rd;
    logic [IW-1:0] rd_idx, wr_idx;
    logic        wr_en;
    logic [64:0] wr_data;

    logic [47:0] r_base;
    logic [31:0] r_size;
    logic [CW-1:0] r_cnt;
    logic [3:0]  r_st;
    logic [CW-1:0] r_k, r_m;
    logic        r_op;
    logic [31:0] r_req;
    logic [47:0] r_addr;
    logic [64:0] r_cur, r_hold;
    logic        r_split;
    logic        r_phase;
    logic [47:0] r_baddr;
    logic [1:0]  r_status;
    logic        r_ovalid;
    t_rsp        r_out;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        case (paddr[3])
            1'b0:    prdata = {16'd0, r_base};
            default: prdata = {32'd0, r_size};
        endcase
    end

    logic [31:0] cfg_size, cfg_len;
    assign cfg_size = paddr[3] ? pwdata[31:0] : r_size;
    assign cfg_len  = (cfg_size >= HDR32) ? cfg_size - HDR32 : 32'd0;

    assign o_req_ready = (r_st == S_IDLE) && !cfg_wr;
    assign o_rsp_valid = r_ovalid;
    assign o_rsp = r_out;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        r_rd <= mem[rd_idx];
    end

    logic [31:0] rd_off, rd_len;
    logic        rd_free;
    assign rd_off  = r_rd[31:0];
    assign rd_len  = r_rd[63:32];
    assign rd_free = r_rd[64];

    logic [47:0] rd_daddr;
    assign rd_daddr = r_base + 48'(rd_off) + 48'(HEADER_BYTES);

    logic        seg_fit, seg_split;
    logic [31:0] rest;
    assign seg_fit   = rd_free && (rd_len >= r_req);
    assign rest      = rd_len - r_req;
    assign seg_split = (rest >= HDR32) && (r_cnt < MAXC);

    logic [31:0] mlen;
    assign mlen = r_cur[63:32] + HDR32 + rd_len;

    always_comb begin
        rd_idx  = r_k[IW-1:0];
        wr_en   = 1'b0;
        wr_idx  = r_k[IW-1:0];
        wr_data = r_cur;
        case (r_st)
            S_NRD: rd_idx = IW'(r_k + 1'b1);
            S_PRD: rd_idx = IW'(r_k - 1'b1);
            S_INS_R, S_DEL_R: rd_idx = r_m[IW-1:0];
            S_INS_W: begin
                wr_en = 1'b1; wr_idx = IW'(r_m + 1'b1); wr_data = r_rd;
            end
            S_DEL_W: begin
                wr_en = 1'b1; wr_idx = IW'(r_m - 1'b1); wr_data = r_rd;
            end
            S_CFGW, S_WR0, S_FWR: wr_en = 1'b1;
            S_WR1: begin
                wr_en = 1'b1; wr_idx = IW'(r_k + 1'b1); wr_data = r_hold;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_k <= '0;
            r_base <= '0;
            r_size <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (cfg_wr) begin
                        if (paddr[3] == 1'b0) r_base <= pwdata[47:0];
                        else r_size <= pwdata[31:0];
                        r_cnt <= CW'(1);
                        r_k <= '0;
                        r_cur <= {1'b1, cfg_len, 32'd0};
                        r_st <= S_CFGW;
                    end else if (i_req_valid) begin
                        r_op <= i_req.operation;
                        r_req <= (i_req.request_size < 32'(MINALLOC)) ?
                            i_req.request_size + 32'(MINALLOC) : i_req.request_size;
                        r_addr <= i_req.release_address;
                        r_k <= '0;
                        r_st <= S_SRD;
                    end
                end
                S_CFGW: r_st <= S_IDLE;
                S_SRD: begin
                    if (r_k < r_cnt) begin
                        r_st <= S_SCHK;
                    end else begin
                        r_baddr <= '0;
                        r_status <= (r_op == OP_ALLOC) ? ST_OOM : ST_BAD_FREE;
                        r_st <= S_RESP;
                    end
                end
                S_SCHK: begin
                    if (r_op == OP_ALLOC) begin
                        if (seg_fit) begin
                            r_baddr <= rd_daddr;
                            r_status <= ST_OK;
                            if (seg_split) begin
                                r_cur <= {1'b0, r_req, rd_off};
                                r_hold <= {1'b1, rest - HDR32, rd_off + HDR32 + r_req};
                                r_split <= 1'b1;
                                r_m <= r_cnt - 1'b1;
                                r_st <= (r_cnt - 1'b1 > r_k) ? S_INS_R : S_WR0;
                            end else begin
                                r_cur <= {1'b0, rd_len, rd_off};
                                r_split <= 1'b0;
                                r_st <= S_WR0;
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_st <= S_SRD;
                        end
                    end else begin
                        if (!rd_free && rd_daddr == r_addr) begin
                            r_baddr <= '0;
                            r_status <= ST_OK;
                            r_cur <= {1'b1, rd_len, rd_off};
                            if (r_k + 1'b1 < r_cnt) r_st <= S_NRD;
                            else if (r_k != '0) r_st <= S_PRD;
                            else r_st <= S_FWR;
                        end else begin
                            r_k <= r_k + 1'b1;
                            r_st <= S_SRD;
                        end
                    end
                end
                S_INS_R: r_st <= S_INS_W;
                S_INS_W: begin
                    r_m <= r_m - 1'b1;
                    r_st <= (r_m - 1'b1 > r_k) ? S_INS_R : S_WR0;
                end
                S_WR0: r_st <= r_split ? S_WR1 : S_RESP;
                S_WR1: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_st <= S_RESP;
                end
                // free: fold in a free next neighbor, then a free previous one
                S_NRD: r_st <= S_NCHK;
                S_NCHK: begin
                    if (rd_free) begin
                        r_cur[63:32] <= mlen;
                        r_m <= r_k + 2'd2;
                        r_phase <= 1'b0;
                        r_st <= S_DEL_R;
                    end else begin
                        r_st <= (r_k != '0) ? S_PRD : S_FWR;
                    end
                end
                S_PRD: r_st <= S_PCHK;
                S_PCHK: begin
                    if (rd_free) begin
                        r_cur <= {1'b1, mlen, rd_off};
                        r_m <= r_k + 1'b1;
                        r_k <= r_k - 1'b1;
                        r_phase <= 1'b1;
                        r_st <= S_DEL_R;
                    end else begin
                        r_st <= S_FWR;
                    end
                end
                S_DEL_R: begin
                    if (r_m < r_cnt) begin
                        r_st <= S_DEL_W;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                        r_st <= (!r_phase && r_k != '0) ? S_PRD : S_FWR;
                    end
                end
                S_DEL_W: begin
                    r_m <= r_m + 1'b1;
                    r_st <= S_DEL_R;
                end
                S_FWR: r_st <= S_RESP;
                S_RESP: if (!r_ovalid || i_rsp_ready) begin
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_st == S_RESP && (!r_ovalid || i_rsp_ready)) begin
            r_ovalid <= 1'b1;
            r_out <= '{block_address: r_baddr, status: r_status};
        end else if (i_rsp_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    `FFH_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= MAXC)
    `FFH_ASSERT_IMP(a_busy_nr, i_clk, i_rst_n, r_st != S_IDLE, !o_req_ready)
    `FFH_ASSERT_NEXT(a_accept, i_clk, i_rst_n,
        i_req_valid && o_req_ready, r_st == S_SRD)
    `FFH_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n,
        o_rsp_valid && !i_rsp_ready, o_rsp_valid && $stable(o_rsp))

endmodule
